>>> src/assert_macros.svh
// Assertion macros shared by the RTL.
// Both macros expect the clock clk and the active-low reset arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared widths, character codes and types for the binary to decimal text block.
// ----------------------------------------------------------------------------
package sbda_pkg;

	localparam int VALUE_WIDTH = 32;
	// decimal digits needed for 2**VALUE_WIDTH (log10(2) ~ 0.30103)
	localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W       = 4 * DIGITS;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int DCNT_W      = $clog2(DIGITS + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dab_stat_t;

endpackage

>>> src/sbda_dabble.sv
// ----------------------------------------------------------------------------
// sbda_dabble
// Bit-serial double dabble: one magnitude bit enters the BCD register per cycle.
// ----------------------------------------------------------------------------
module sbda_dabble
	import sbda_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [VALUE_WIDTH-1:0]   mag,
	output dab_stat_t                stat,
	output logic [BCD_W-1:0]         bcd
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

endmodule

>>> src/signed_binary_to_decimal_ascii.sv
// The first character leaves once the conversion and the skip of leading zeros are done,
// as early with a sign as without one.
// A new number is taken only in idle, once the last character of the previous one is in the
// output register; the bit-serial double dabble (one bit a cycle) dominates.
// One character word leaves per cycle while out_stall is low.
// Reset (arst_n, async, low) returns the controller to idle and drops out_valid.
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Renders a signed integer as ASCII decimal text, most significant digit first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_binary_to_decimal_ascii
	import sbda_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input word
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	// output character word
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             ascii_char,
	output logic                   last_char
);

	state_t                 state_q, state_d;
	logic                   neg_q, neg_d;
	logic [BCD_W-1:0]       digs_q, digs_d;
	logic [DCNT_W-1:0]      dcnt_q, dcnt_d;
	logic                   out_valid_q, out_valid_d;
	logic [7:0]             ascii_char_q, ascii_char_d;
	logic                   last_char_q, last_char_d;

	logic                   accept;
	logic                   out_free;
	logic [VALUE_WIDTH-1:0] mag;
	logic [3:0]             top_dig;
	dab_stat_t              dab_stat;
	logic [BCD_W-1:0]       dab_bcd;

	assign accept   = in_valid && !in_stall;
	// output register can take a new character this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// unsigned magnitude; the most negative value negates to itself, which is correct
	assign mag     = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
	assign top_dig = digs_q[BCD_W-1 -: 4];

	sbda_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.stat   (dab_stat),
		.bcd    (dab_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		neg_q        <= neg_d;
		digs_q       <= digs_d;
		dcnt_q       <= dcnt_d;
		ascii_char_q <= ascii_char_d;
		last_char_q  <= last_char_d;
	end

	always_comb begin
		state_d      = state_q;
		neg_d        = neg_q;
		digs_d       = digs_q;
		dcnt_d       = dcnt_q;
		out_valid_d  = out_valid_q && out_stall;
		ascii_char_d = ascii_char_q;
		last_char_d  = last_char_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					neg_d   = value[VALUE_WIDTH-1];
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (dab_stat.done) begin
					digs_d  = dab_bcd;
					dcnt_d  = DCNT_W'(DIGITS);
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, always keep the last digit
				if (top_dig == 4'd0 && dcnt_q > DCNT_W'(1)) begin
					digs_d = {digs_q[BCD_W-5:0], 4'h0};
					dcnt_d = dcnt_q - 1'b1;
				end else begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					ascii_char_d = CHAR_MINUS;
					last_char_d  = 1'b0;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					ascii_char_d = CHAR_ZERO + {4'h0, top_dig};
					last_char_d  = (dcnt_q == DCNT_W'(1));
					digs_d       = {digs_q[BCD_W-5:0], 4'h0};
					dcnt_d       = dcnt_q - 1'b1;
					if (dcnt_q == DCNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = ascii_char_q;
	assign last_char  = last_char_q;

	// a number never ends on its sign
	`ASSERT_NEVER(a_last_not_minus,
		out_valid_q && last_char_q && ascii_char_q == CHAR_MINUS, "minus flagged last")
	// converter finishes only while the controller waits for it
	`ASSERT_CLK(a_done_in_conv, dab_stat.done |-> state_q == ST_CONV,
		"converter done outside CONV")
	// converter is never restarted mid conversion
	`ASSERT_NEVER(a_no_restart, accept && dab_stat.busy, "input accepted while converting")
	// digits are emitted only while some remain
	`ASSERT_NEVER(a_dcnt_zero,
		(state_q == ST_EMIT || state_q == ST_SKIP) && dcnt_q == '0, "digit count underflow")

endmodule

>>> dv/tb_signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// tb_signed_binary_to_decimal_ascii
// Self-checking bench for the signed binary to decimal text block: feeds
// signed words, predicts the character stream of each and checks every
// character word that leaves, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_signed_binary_to_decimal_ascii;
	import sbda_pkg::*;

	localparam int N_DIRECTED  = 20;
	localparam int N_RANDOM    = 350;
	// cycles with no accept on either side before the run is declared hung
	localparam int HANG_LIMIT  = 2000;
	localparam int DRAIN_TAIL  = 60;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [VALUE_WIDTH-1:0] value = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [7:0]             ascii_char;
	logic                   last_char;

	// characters still owed by the block, oldest first
	char_word_t char_q[$];
	int         errors = 0;
	int         hang_cnt = 0;
	// set during the stretch where neither side idles
	bit         quiet = 1'b0;

	// Directed table. Rows with text are read off at a glance;
	// rows with an empty text go through the predictor.
	logic [VALUE_WIDTH-1:0] dir_value [N_DIRECTED] = '{
		32'd0,          // right after reset: zero is a lone '0'
		32'd1,
		-32'sd1,
		32'd9,
		32'd10,
		-32'sd10,
		32'h7FFF_FFFF,  // most positive
		32'h8000_0000,  // most negative: ten digits after the sign
		32'h8000_0001,
		32'd1000000000,
		32'd999999999,
		-32'sd999999999,
		32'h5555_5555,
		32'hAAAA_AAAA,
		32'h0000_FFFF,
		32'hFFFF_0000,
		32'd100,
		-32'sd100,
		32'd123456789,
		32'hFFFF_FFFE
	};
	string dir_text [N_DIRECTED] = '{
		"0", "1", "-1", "9", "10", "-10",
		"2147483647", "-2147483648", "-2147483647",
		"1000000000", "999999999", "-999999999",
		"", "", "", "", "", "", "", ""
	};

	signed_binary_to_decimal_ascii dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

	always #5 clk = ~clk;

	// Predictor: queue the decimal text of one word, sign first, msd first.
	function automatic void predict_decimal_text(logic [VALUE_WIDTH-1:0] v);
		logic                   neg;
		logic [VALUE_WIDTH-1:0] mag;
		logic [3:0]             dig [20];
		int                     n;
		char_word_t             w;
		neg = v[VALUE_WIDTH-1];
		// unsigned magnitude, so the most negative word needs no special path
		mag = neg ? (~v + 1'b1) : v;
		n = 0;
		if (mag == '0) begin
			w.ch = CHAR_ZERO;
			w.last = 1'b1;
			char_q.push_back(w);
			return;
		end
		while (mag != '0) begin
			dig[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end
		if (neg) begin
			w.ch = CHAR_MINUS;
			w.last = 1'b0;
			char_q.push_back(w);
		end
		for (int j = n - 1; j >= 0; j--) begin
			w.ch = CHAR_ZERO + 8'(dig[j]);
			w.last = (j == 0);
			char_q.push_back(w);
		end
	endfunction

	// Queue a text typed into the table.
	function automatic void queue_text(string txt);
		char_word_t w;
		for (int i = 0; i < txt.len(); i++) begin
			w.ch = txt[i];
			w.last = (i == txt.len() - 1);
			char_q.push_back(w);
		end
	endfunction

	// Random word with a spread of text lengths and signs.
	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		logic [VALUE_WIDTH-1:0] v;
		logic [VALUE_WIDTH-1:0] p10;
		case ($urandom_range(0, 5))
			0, 1: begin
				v = $urandom;
			end
			2: begin
				v = $urandom_range(0, 99);
			end
			3: begin
				// around a power of ten, where the digit count steps
				p10 = 1;
				repeat ($urandom_range(0, 9)) p10 = p10 * 10;
				v = p10 + $urandom_range(0, 2) - 1;
			end
			4: begin
				// near either end of the range
				v = $urandom_range(0, 1) ? (32'h7FFF_FFFF - $urandom_range(0, 15))
				                         : (32'h8000_0000 + $urandom_range(0, 15));
				return v;
			end
			default: begin
				v = $urandom >> $urandom_range(0, 31);
			end
		endcase
		if ($urandom_range(0, 1))
			v = ~v + 1'b1;
		return v;
	endfunction

	// Offer one word, with random idle cycles ahead of it, and log its text
	// at the edge where it is taken.
	task automatic send_word(logic [VALUE_WIDTH-1:0] v, string txt);
		while (!quiet && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		if (txt.len() != 0)
			queue_text(txt);
		else
			predict_decimal_text(v);
	endtask

	// Receiver: check each accepted character word, then pick the next stall.
	always @(posedge clk) begin
		char_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (char_q.size() == 0) begin
				$display("%0t: unexpected character word: expected none, actual ch=%h last=%b",
				         $time, ascii_char, last_char);
				errors++;
			end else begin
				w = char_q.pop_front();
				if (ascii_char !== w.ch) begin
					$display("%0t: ascii_char mismatch: expected %h, actual %h",
					         $time, w.ch, ascii_char);
					errors++;
				end
				if (last_char !== w.last) begin
					$display("%0t: last_char mismatch: expected %b, actual %b",
					         $time, w.last, last_char);
					errors++;
				end
			end
		end
		out_stall <= !quiet && ($urandom_range(0, 99) < 33);
	end

	// Watchdog: counts cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				hang_cnt <= 0;
			else
				hang_cnt <= hang_cnt + 1;
			if (hang_cnt >= HANG_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d characters owed",
				         $time, HANG_LIMIT, char_q.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++)
			send_word(dir_value[i], dir_text[i]);

		// random part, with a quiet stretch and one full drain in the middle
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 150 && i < 230);
			if (i == 100) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (char_q.size() != 0)
					@(posedge clk);
			end
			send_word(pick_value(), "");
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		// drain, then give a stray late word time to show up
		while (char_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (errors == 0 && char_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (char_q.size() != 0)
				$display("%0t: %0d characters never arrived", $time, char_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
